// ----- rtl/tcc_pkg.sv -----
// Shared constants, codes and control types of the text console engine.
`timescale 1ns / 1ps
`default_nettype none

package tcc_pkg;

  // Console geometry
  localparam int CONSOLES     = 4;
  localparam int REGION_CELLS = 4096;
  localparam int LINE_CELLS   = 80;
  localparam int SCREEN_CELLS = 2000;

  // Field widths of the item and result
  localparam int OPCODE_W  = 2;
  localparam int CONSOLE_W = 2;
  localparam int BYTE_W    = 8;
  localparam int CELL_W    = 14;

  // Internal address width: holds every region end plus a screen and a line
  localparam int ADDR_W = $clog2(CONSOLES * REGION_CELLS + SCREEN_CELLS + LINE_CELLS + 1);
  // Offset of a cell inside its region
  localparam int OFF_W  = $clog2(REGION_CELLS);
  // Index into the per-console tables
  localparam int TBL_IDX_W = (CONSOLES > 1) ? $clog2(CONSOLES) : 1;

  // Division of a region offset by LINE_CELLS through a reciprocal
  localparam int DIV_SHIFT = OFF_W + 1;
  localparam int RECIP     = (1 << DIV_SHIFT) / LINE_CELLS;
  localparam int RECIP_W   = $clog2(RECIP + 1);
  localparam int PROD_W    = OFF_W + RECIP_W;
  localparam int Q_W       = PROD_W - DIV_SHIFT;

  // Character codes
  localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [BYTE_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [BYTE_W-1:0] CH_SPACE     = 8'd32;

  // Attribute after reset
  localparam logic [BYTE_W-1:0] ATTR_RESET = 8'd7;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUT         = 2'd0,
    OP_SCROLL_UP   = 2'd1,
    OP_SCROLL_DOWN = 2'd2,
    OP_SELECT      = 2'd3
  } tcc_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_REM,
    S_EDIT,
    S_SCROLL,
    S_EMIT
  } tcc_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic div;
    logic rem;
    logic edit;
    logic scroll;
    logic emit;
  } tcc_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic item_in_range;
    logic item_newline;
    logic is_put;
    logic need_scroll;
  } tcc_status_t;

endpackage

`default_nettype wire

// ----- rtl/tcc_if.sv -----
// Valid/ready channel interfaces for the console items and results.
`timescale 1ns / 1ps
`default_nettype none

interface tcc_in_if;
  import tcc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [OPCODE_W-1:0]  opcode;
  logic [CONSOLE_W-1:0] console;
  logic [BYTE_W-1:0]    char_code;

  modport source (output valid, output opcode, output console, output char_code,
                  input ready);
  modport sink (input valid, input opcode, input console, input char_code,
                output ready);
endinterface

interface tcc_out_if;
  import tcc_pkg::*;

  logic              valid;
  logic              ready;
  logic              mem_write;
  logic [CELL_W-1:0] mem_cell;
  logic [BYTE_W-1:0] mem_char;
  logic [BYTE_W-1:0] mem_attr;
  logic [CELL_W-1:0] cursor_position;
  logic [CELL_W-1:0] display_start;
  logic              crtc_update;

  modport source (output valid, output mem_write, output mem_cell, output mem_char,
                  output mem_attr, output cursor_position, output display_start,
                  output crtc_update, input ready);
  modport sink (input valid, input mem_write, input mem_cell, input mem_char,
                input mem_attr, input cursor_position, input display_start,
                input crtc_update, output ready);
endinterface

`default_nettype wire

// ----- rtl/tcc_ctrl.sv -----
// Controller state machine of the text console engine.
`timescale 1ns / 1ps
`default_nettype none

module tcc_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire tcc_pkg::tcc_status_t status,
  output tcc_pkg::tcc_cmd_t         cmd
);
  import tcc_pkg::*;

  tcc_state_t state, state_next;
  logic       out_valid_next;

  // Hold state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Sequence one item through decode, line division, edit, scroll catch-up and emit
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        // Hold off input transfers while in reset
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load = 1'b1;
          if (!status.item_in_range) begin
            state_next = S_EMIT;
          end else if (status.item_newline) begin
            state_next = S_DIV;
          end else begin
            state_next = S_EDIT;
          end
        end
      end
      S_DIV: begin
        cmd.div    = 1'b1;
        state_next = S_REM;
      end
      S_REM: begin
        cmd.rem    = 1'b1;
        state_next = S_EDIT;
      end
      S_EDIT: begin
        cmd.edit   = 1'b1;
        state_next = status.is_put ? S_SCROLL : S_EMIT;
      end
      S_SCROLL: begin
        if (status.need_scroll) begin
          cmd.scroll = 1'b1;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid || out_ready) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Set on emit, drop after the result transfer
  always_comb begin
    if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tcc_datapath.sv -----
// Datapath of the text console engine: tables, cursor math, scroll and result register.
`timescale 1ns / 1ps
`default_nettype none

module tcc_datapath (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire tcc_pkg::tcc_cmd_t              cmd,
  output tcc_pkg::tcc_status_t                status,
  input  wire logic                           cfg_we,
  input  wire logic [tcc_pkg::BYTE_W-1:0]     cfg_wdata,
  input  wire logic [tcc_pkg::OPCODE_W-1:0]   item_opcode,
  input  wire logic [tcc_pkg::CONSOLE_W-1:0]  item_console,
  input  wire logic [tcc_pkg::BYTE_W-1:0]     item_char_code,
  output logic                                res_mem_write,
  output logic [tcc_pkg::CELL_W-1:0]          res_mem_cell,
  output logic [tcc_pkg::BYTE_W-1:0]          res_mem_char,
  output logic [tcc_pkg::BYTE_W-1:0]          res_mem_attr,
  output logic [tcc_pkg::CELL_W-1:0]          res_cursor_position,
  output logic [tcc_pkg::CELL_W-1:0]          res_display_start,
  output logic                                res_crtc_update
);
  import tcc_pkg::*;

  localparam logic [ADDR_W-1:0] REGION_ADDR = ADDR_W'(REGION_CELLS);
  localparam logic [ADDR_W-1:0] LINE_ADDR   = ADDR_W'(LINE_CELLS);
  localparam logic [ADDR_W-1:0] SCREEN_ADDR = ADDR_W'(SCREEN_CELLS);
  localparam logic [ADDR_W-1:0] ONE_ADDR    = ADDR_W'(1);
  localparam logic [OFF_W-1:0]  LINE_OFF    = OFF_W'(LINE_CELLS);

  // Per-console state
  logic [ADDR_W-1:0] cursor_table [CONSOLES];
  logic [ADDR_W-1:0] start_table  [CONSOLES];
  logic [BYTE_W-1:0] attr;

  // Working registers of the item in flight
  tcc_op_t            op;
  logic [TBL_IDX_W-1:0] con_idx;
  logic [BYTE_W-1:0]  ch;
  logic               in_range;
  logic [ADDR_W-1:0]  base;
  logic [ADDR_W-1:0]  cur;
  logic [ADDR_W-1:0]  start;
  logic [Q_W-1:0]     q_est;
  logic [OFF_W-1:0]   rem_raw;
  logic               wr;
  logic [ADDR_W-1:0]  wcell;
  logic [BYTE_W-1:0]  wch;

  logic [TBL_IDX_W-1:0] item_idx;
  logic                 item_in_range;
  logic [ADDR_W-1:0]    limit;
  logic [ADDR_W-1:0]    screen_end;
  logic [OFF_W-1:0]     off;
  logic [PROD_W-1:0]    prod;
  logic [OFF_W-1:0]     rem;
  logic [ADDR_W-1:0]    nl_cur;
  logic                 nl_ok;
  logic                 bs_ok;
  logic                 pr_ok;
  logic                 scr_room;
  logic                 need_scroll;

  assign item_idx      = TBL_IDX_W'(item_console);
  assign item_in_range = int'(item_console) < CONSOLES;

  // Region bounds and screen window
  assign limit       = base + REGION_ADDR;
  assign screen_end  = start + SCREEN_ADDR;
  assign scr_room    = screen_end < limit;
  assign need_scroll = (cur >= screen_end) && scr_room;

  // Line arithmetic: offset, reciprocal product, corrected remainder
  assign off    = OFF_W'(cur - base);
  assign prod   = PROD_W'(off) * PROD_W'(RECIP);
  assign rem    = (rem_raw >= LINE_OFF) ? (rem_raw - LINE_OFF) : rem_raw;
  assign nl_cur = cur - ADDR_W'(rem) + LINE_ADDR;
  assign nl_ok  = cur < (limit - LINE_ADDR);
  assign bs_ok  = cur > base;
  assign pr_ok  = cur < (limit - ONE_ADDR);

  always_comb begin
    status               = '0;
    status.item_in_range = item_in_range;
    status.item_newline  = (tcc_op_t'(item_opcode) == OP_PUT) &&
                           (item_char_code == CH_NEWLINE);
    status.is_put        = (op == OP_PUT);
    status.need_scroll   = need_scroll;
  end

  // Hold attribute and per-console tables; write back on emit
  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= ATTR_RESET;
      for (int i = 0; i < CONSOLES; i++) begin
        cursor_table[i] <= ADDR_W'(i * REGION_CELLS);
        start_table[i]  <= ADDR_W'(i * REGION_CELLS);
      end
    end else begin
      if (cfg_we) begin
        attr <= cfg_wdata;
      end
      if (cmd.emit && in_range) begin
        cursor_table[con_idx] <= cur;
        start_table[con_idx]  <= start;
      end
    end
  end

  // Load, divide, edit and scroll the item in flight
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op       <= tcc_op_t'(item_opcode);
      con_idx  <= item_idx;
      ch       <= item_char_code;
      in_range <= item_in_range;
      base     <= ADDR_W'(item_console) * REGION_ADDR;
      cur      <= cursor_table[item_idx];
      start    <= start_table[item_idx];
      wr       <= 1'b0;
    end
    if (cmd.div) begin
      q_est <= prod[PROD_W-1:DIV_SHIFT];
    end
    if (cmd.rem) begin
      rem_raw <= OFF_W'(PROD_W'(off) - PROD_W'(q_est) * PROD_W'(LINE_CELLS));
    end
    if (cmd.edit) begin
      case (op)
        OP_PUT: begin
          if (ch == CH_NEWLINE) begin
            if (nl_ok) begin
              cur <= nl_cur;
            end
          end else if (ch == CH_BACKSPACE) begin
            if (bs_ok) begin
              cur   <= cur - ONE_ADDR;
              wr    <= 1'b1;
              wcell <= cur - ONE_ADDR;
              wch   <= CH_SPACE;
            end
          end else if (pr_ok) begin
            cur   <= cur + ONE_ADDR;
            wr    <= 1'b1;
            wcell <= cur;
            wch   <= ch;
          end
        end
        OP_SCROLL_UP: begin
          if (start > base) begin
            start <= start - LINE_ADDR;
          end
        end
        OP_SCROLL_DOWN: begin
          if (scr_room) begin
            start <= start + LINE_ADDR;
          end
        end
        OP_SELECT: begin
        end
        default: begin
        end
      endcase
    end
    if (cmd.scroll) begin
      start <= start + LINE_ADDR;
    end
  end

  // Capture the result; zero every field for a console out of range
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      res_mem_write       <= in_range && wr;
      res_mem_cell        <= (in_range && wr) ? CELL_W'(wcell) : '0;
      res_mem_char        <= (in_range && wr) ? wch : '0;
      res_mem_attr        <= (in_range && wr) ? attr : '0;
      res_cursor_position <= in_range ? CELL_W'(cur) : '0;
      res_display_start   <= in_range ? CELL_W'(start) : '0;
      res_crtc_update     <= in_range;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/text_console_cursor_scroll.sv -----
// Top level of the multi-console text engine with cursor and scroll tracking.
// Each console owns one region of cells and keeps a cursor and a display start.
// A put item writes a character (a blank for backspace, none for newline), moves
// the cursor and then scrolls the display start down one line per cycle until the
// cursor is on screen or the screen meets the region end; scroll items move the
// start one line, select reports a console. Every item gives one result with the
// cell write, if any, and the CRTC cursor and start. From input transfer to result
// load, a put is loaded, edited, scrolled and emitted; a newline first divides its
// region offset by the line width via a reciprocal and corrects the remainder;
// scroll and select items are loaded, edited and emitted; an item for a console
// out of range goes from load to emit. The next item is taken in the cycle after
// the result is loaded, while the result register still waits for its transfer.
`timescale 1ns / 1ps
`default_nettype none

module text_console_cursor_scroll (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [tcc_pkg::BYTE_W-1:0] cfg_wdata,
  tcc_in_if.sink                          item,
  tcc_out_if.source                       result
);
  import tcc_pkg::*;

  tcc_cmd_t    cmd;
  tcc_status_t status;
  logic        in_ready;
  logic        out_valid;

  // Sequence each item
  tcc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Compute cursor, start and cell write
  tcc_datapath u_datapath (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .status              (status),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .item_opcode         (item.opcode),
    .item_console        (item.console),
    .item_char_code      (item.char_code),
    .res_mem_write       (result.mem_write),
    .res_mem_cell        (result.mem_cell),
    .res_mem_char        (result.mem_char),
    .res_mem_attr        (result.mem_attr),
    .res_cursor_position (result.cursor_position),
    .res_display_start   (result.display_start),
    .res_crtc_update     (result.crtc_update)
  );

  assign item.ready   = in_ready;
  assign result.valid = out_valid;

endmodule

`default_nettype wire

// ----- test/text_console_cursor_scroll_test.sv -----
// Self-checking testbench for the multi-console text engine with cursor and scroll.
`timescale 1ns / 1ps

module text_console_cursor_scroll_test;
  import tcc_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASES        = 9;
  localparam int PHASE_ITEMS   = 60;
  localparam int SETTLE_CYCLES = 24;

  typedef struct packed {
    logic              mem_write;
    logic [CELL_W-1:0] mem_cell;
    logic [BYTE_W-1:0] mem_char;
    logic [BYTE_W-1:0] mem_attr;
    logic [CELL_W-1:0] cursor_position;
    logic [CELL_W-1:0] display_start;
    logic              crtc_update;
  } crtc_result_t;

  // Tracks per-console cursor and start, and the CRTC results still owed
  class console_tracker;
    int                cursor_tbl[CONSOLES];
    int                start_tbl[CONSOLES];
    int                active_console;
    logic [BYTE_W-1:0] attr;
    crtc_result_t      owed_results[$];
    int                errors;

    function new();
      for (int i = 0; i < CONSOLES; i++) begin
        cursor_tbl[i] = i * REGION_CELLS;
        start_tbl[i]  = i * REGION_CELLS;
      end
      active_console = 0;
      attr = ATTR_RESET;
      errors = 0;
    endfunction

    task report(input string msg);
      errors++;
      $display("ERROR @%0t: %s", $time, msg);
    endtask

    function int owed_count();
      return owed_results.size();
    endfunction

    // Work out the result of one accepted item and advance the console state
    function void note_item(input tcc_op_t op, input logic [CONSOLE_W-1:0] con,
                            input logic [BYTE_W-1:0] ch);
      crtc_result_t r;
      int base;
      int limit;
      int cur;
      r = '0;
      if (int'(con) >= CONSOLES) begin
        owed_results.push_back(r);
        return;
      end
      base  = int'(con) * REGION_CELLS;
      limit = base + REGION_CELLS;
      case (op)
        OP_PUT: begin
          cur = cursor_tbl[con];
          if (ch == CH_NEWLINE) begin
            if (cur < limit - LINE_CELLS)
              cur = base + LINE_CELLS * ((cur - base) / LINE_CELLS + 1);
          end else if (ch == CH_BACKSPACE) begin
            if (cur > base) begin
              cur--;
              r.mem_write = 1'b1;
              r.mem_cell  = CELL_W'(cur);
              r.mem_char  = CH_SPACE;
              r.mem_attr  = attr;
            end
          end else if (cur < limit - 1) begin
            r.mem_write = 1'b1;
            r.mem_cell  = CELL_W'(cur);
            r.mem_char  = ch;
            r.mem_attr  = attr;
            cur++;
          end
          cursor_tbl[con] = cur;
          // Scroll down until the cursor is on screen, stop at region end
          while (cur >= start_tbl[con] + SCREEN_CELLS &&
                 start_tbl[con] + SCREEN_CELLS < limit)
            start_tbl[con] += LINE_CELLS;
        end
        OP_SCROLL_UP: begin
          if (start_tbl[con] > base) start_tbl[con] -= LINE_CELLS;
        end
        OP_SCROLL_DOWN: begin
          if (start_tbl[con] + SCREEN_CELLS < limit) start_tbl[con] += LINE_CELLS;
        end
        default: begin
          active_console = int'(con);
        end
      endcase
      r.cursor_position = CELL_W'(cursor_tbl[con]);
      r.display_start   = CELL_W'(start_tbl[con]);
      r.crtc_update     = 1'b1;
      owed_results.push_back(r);
    endfunction

    task check_field(input string name, input int got, input int want);
      if (got != want) report($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // Compare one transferred result with the oldest one owed
    task check_result(input crtc_result_t got);
      crtc_result_t want;
      if (owed_results.size() == 0) begin
        report($sformatf("result with nothing owed: %p", got));
        return;
      end
      want = owed_results.pop_front();
      check_field("mem_write", got.mem_write, want.mem_write);
      check_field("mem_cell", got.mem_cell, want.mem_cell);
      check_field("mem_char", got.mem_char, want.mem_char);
      check_field("mem_attr", got.mem_attr, want.mem_attr);
      check_field("cursor_position", got.cursor_position, want.cursor_position);
      check_field("display_start", got.display_start, want.display_start);
      check_field("crtc_update", got.crtc_update, want.crtc_update);
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_we;
  logic [BYTE_W-1:0] cfg_wdata;
  int                cycle_count = 0;
  int                send_gap_max = 0;
  int                accept_stall_max = 0;
  console_tracker    board;

  tcc_in_if  item_ch ();
  tcc_out_if result_ch ();

  text_console_cursor_scroll u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item      (item_ch),
    .result    (result_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Present one item after a random gap and hold it until the transfer
  task automatic send_item(input tcc_op_t op, input logic [CONSOLE_W-1:0] con,
                           input logic [BYTE_W-1:0] ch);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid     <= 1'b1;
    item_ch.opcode    <= op;
    item_ch.console   <= con;
    item_ch.char_code <= ch;
    do @(posedge clk); while (!(item_ch.valid && item_ch.ready));
    board.note_item(op, con, ch);
  endtask

  // Draw one item: mostly on the focus console, newline share set per phase
  task automatic send_random(input int focus, input int newline_pct);
    int pick;
    logic [CONSOLE_W-1:0] con;
    pick = $urandom_range(0, 99);
    con  = (pick < 85) ? CONSOLE_W'(focus) : CONSOLE_W'($urandom_range(0, 3));
    pick = $urandom_range(0, 99);
    if (pick < newline_pct)
      send_item(OP_PUT, con, CH_NEWLINE);
    else if (pick < newline_pct + 10)
      send_item(OP_PUT, con, CH_BACKSPACE);
    else if (pick < 88)
      send_item(OP_PUT, con, BYTE_W'($urandom_range(0, 255)));
    else if (pick < 93)
      send_item(OP_SCROLL_UP, con, BYTE_W'($urandom_range(0, 255)));
    else if (pick < 98)
      send_item(OP_SCROLL_DOWN, con, BYTE_W'($urandom_range(0, 255)));
    else
      send_item(OP_SELECT, con, BYTE_W'($urandom_range(0, 255)));
  endtask

  // Drop valid and hold until every owed result has come back
  task automatic wait_idle();
    item_ch.valid <= 1'b0;
    while (board.owed_count() != 0) @(posedge clk);
  endtask

  task automatic write_attribute(input logic [BYTE_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    board.attr = value;
    cfg_we <= 1'b0;
  endtask

  // Result side: stall at random, check every transfer
  initial begin : result_sink
    int stall;
    crtc_result_t got;
    result_ch.ready <= 1'b0;
    forever begin
      stall = $urandom_range(0, accept_stall_max);
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!(result_ch.valid && result_ch.ready));
      got.mem_write       = result_ch.mem_write;
      got.mem_cell        = result_ch.mem_cell;
      got.mem_char        = result_ch.mem_char;
      got.mem_attr        = result_ch.mem_attr;
      got.cursor_position = result_ch.cursor_position;
      got.display_start   = result_ch.display_start;
      got.crtc_update     = result_ch.crtc_update;
      board.check_result(got);
    end
  end

  initial begin : stimulus
    int focus;
    int newline_pct;
    board = new();
    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    item_ch.valid     <= 1'b0;
    item_ch.opcode    <= OP_PUT;
    item_ch.console   <= '0;
    item_ch.char_code <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    write_attribute(8'hFF);

    // Directed: region base cases, byte extremes, every operation
    accept_stall_max = 14;
    send_item(OP_SCROLL_UP, 2'd0, 8'h00);
    send_item(OP_PUT, 2'd0, CH_BACKSPACE);
    send_item(OP_PUT, 2'd0, 8'h41);
    send_item(OP_PUT, 2'd0, 8'h00);
    send_item(OP_PUT, 2'd0, 8'hFF);
    send_item(OP_PUT, 2'd0, CH_BACKSPACE);
    send_item(OP_PUT, 2'd0, CH_NEWLINE);
    send_item(OP_PUT, 2'd0, 8'h55);
    send_item(OP_PUT, 2'd1, 8'hAA);
    send_item(OP_SCROLL_DOWN, 2'd1, 8'h00);
    send_item(OP_SCROLL_DOWN, 2'd1, 8'hFF);
    send_item(OP_SCROLL_UP, 2'd1, 8'h00);
    send_item(OP_SELECT, 2'd2, 8'h00);
    send_item(OP_SELECT, 2'd3, 8'hFF);
    send_item(OP_SELECT, 2'd0, 8'h00);
    send_item(OP_PUT, 2'd2, CH_NEWLINE);
    send_item(OP_PUT, 2'd3, CH_SPACE);
    send_item(OP_SCROLL_UP, 2'd3, 8'hFF);
    send_item(OP_PUT, 2'd1, CH_NEWLINE);

    // Random phases: the first three drive console 3 to its region end
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      case (phase)
        0: write_attribute(8'h00);
        PHASES - 1: write_attribute(ATTR_RESET);
        default: write_attribute(BYTE_W'($urandom_range(0, 255)));
      endcase
      if (phase == 3) begin
        send_gap_max     = 0;
        accept_stall_max = 0;
      end else begin
        send_gap_max     = ($urandom_range(0, 1) != 0) ? 14 : $urandom_range(0, 3);
        accept_stall_max = ($urandom_range(0, 1) != 0) ? 14 : $urandom_range(0, 3);
      end
      if (phase < 3) begin
        focus       = 3;
        newline_pct = (phase < 2) ? 60 : 10;
      end else begin
        focus       = $urandom_range(0, 3);
        newline_pct = $urandom_range(5, 60);
      end
      for (int n = 0; n < PHASE_ITEMS; n++) send_random(focus, newline_pct);
    end

    // Drain, let the block settle, then give the verdict
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.owed_count() != 0)
      board.report($sformatf("%0d results never arrived", board.owed_count()));
    if (board.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- text_console_cursor_scroll.f -----
rtl/tcc_pkg.sv
rtl/tcc_if.sv
rtl/tcc_ctrl.sv
rtl/tcc_datapath.sv
rtl/text_console_cursor_scroll.sv
test/text_console_cursor_scroll_test.sv
